### src/ascii_distance_line_parser_macros.svh
// assertion macros for the ascii distance line parser
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASCII_DISTANCE_LINE_PARSER_MACROS_SVH
`define ASCII_DISTANCE_LINE_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ADLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ADLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/adlp_pkg.sv
// shared types and constants of the ascii distance line parser
// no dependencies
`timescale 1ns / 1ps

package adlp_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 16;
    localparam int RAW_W   = 24;
    localparam int FRAC_W  = 2;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;

    // frame rules
    localparam int                MIN_FRAME_CHARS = 3;
    localparam logic [FRAC_W-1:0] MAX_FRAC_DIGITS = 2'd2;
    localparam logic [RAW_W-1:0]  RAW_SAT         = 24'hFFFFFF;

    // configuration register indexes
    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    // reset values of the bounds
    localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 16'd20;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 16'd4000;

    // one finished frame from the parse core
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [RAW_W-1:0]  raw;
    } adlp_result_t;

endpackage

### src/adlp_in_reg.sv
// input register of the ascii distance line parser
// depends on adlp_pkg
`timescale 1ns / 1ps

module adlp_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [adlp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        blocked,
    output logic                        step,
    output logic [adlp_pkg::BYTE_W-1:0] byte_q
);
    import adlp_pkg::*;

    logic              byte_valid_reg;
    logic              byte_valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // held byte moves on unless the result side is full and stalled
    assign step     = byte_valid_reg && !blocked;
    assign in_stall = byte_valid_reg && blocked;
    assign byte_q   = byte_reg;

    // valid bit follows the input when the register can be refilled
    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (!in_stall)
        begin
            byte_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    // payload capture on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

### src/adlp_parse_core.sv
// frame parse state and result arithmetic of the ascii distance line parser
// depends on adlp_pkg and ascii_distance_line_parser_macros.svh
`timescale 1ns / 1ps

`include "ascii_distance_line_parser_macros.svh"

module adlp_parse_core #(
    parameter int MAX_KEPT_CHARS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [adlp_pkg::BYTE_W-1:0] byte_q,
    input  logic [adlp_pkg::DIST_W-1:0] min_distance_cm,
    input  logic [adlp_pkg::DIST_W-1:0] max_distance_cm,
    output adlp_pkg::adlp_result_t      result
);
    import adlp_pkg::*;

    localparam int              CNT_W   = $clog2(MAX_KEPT_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT_CHARS);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_CHARS);
    localparam int              MUL_W   = RAW_W + 7;

    logic [RAW_W-1:0]  acc_reg;
    logic [RAW_W-1:0]  acc_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              dot_seen_reg;
    logic              dot_seen_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic              stopped_reg;
    logic              stopped_next;

    logic              is_digit;
    logic              is_dot;
    logic              is_term;
    logic [RAW_W+3:0]  push_sum;
    logic [RAW_W-1:0]  pushed;
    logic [MUL_W-1:0]  scaled;
    logic [RAW_W-1:0]  raw;

    // character classes
    assign is_digit = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
    assign is_dot   = (byte_q == CHAR_DOT);
    assign is_term  = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);

    // acc * 10 + digit with saturation
    always_comb
    begin
        push_sum = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + {{RAW_W{1'b0}}, byte_q[3:0]};
        pushed   = (push_sum > {4'b0, RAW_SAT}) ? RAW_SAT : push_sum[RAW_W-1:0];
    end

    // scale to centimetres by the missing fraction digits
    always_comb
    begin
        case (frac_reg)
            2'd0:    scaled = {7'b0, acc_reg} * MUL_W'(100);
            2'd1:    scaled = {7'b0, acc_reg} * MUL_W'(10);
            default: scaled = {7'b0, acc_reg};
        endcase
        raw = (scaled > {7'b0, RAW_SAT}) ? RAW_SAT : scaled[RAW_W-1:0];
    end

    // clamp and result on a terminator
    always_comb
    begin
        result.valid = step && is_term && (count_reg >= CNT_MIN);
        result.raw   = raw;
        if (raw < {8'b0, min_distance_cm})
        begin
            result.distance = min_distance_cm;
        end
        else if (raw > {8'b0, max_distance_cm})
        begin
            result.distance = max_distance_cm;
        end
        else
        begin
            result.distance = raw[DIST_W-1:0];
        end
    end

    // parse state update
    always_comb
    begin
        acc_next      = acc_reg;
        count_next    = count_reg;
        dot_seen_next = dot_seen_reg;
        frac_next     = frac_reg;
        stopped_next  = stopped_reg;
        if (step)
        begin
            if (is_digit || is_dot)
            begin
                if (count_reg < CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                    if (!stopped_reg)
                    begin
                        if (is_dot)
                        begin
                            if (dot_seen_reg)
                            begin
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                dot_seen_next = 1'b1;
                            end
                        end
                        else if (dot_seen_reg)
                        begin
                            if (frac_reg < MAX_FRAC_DIGITS)
                            begin
                                acc_next  = pushed;
                                frac_next = frac_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            acc_next = pushed;
                        end
                    end
                end
            end
            else if (is_term)
            begin
                acc_next      = '0;
                count_next    = '0;
                dot_seen_next = 1'b0;
                frac_next     = '0;
                stopped_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            count_reg    <= '0;
            dot_seen_reg <= 1'b0;
            frac_reg     <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            dot_seen_reg <= dot_seen_next;
            frac_reg     <= frac_next;
            stopped_reg  <= stopped_next;
        end
    end

    // state consistency checks
    `ADLP_ASSERT_NOW(a_count_bound, 1'b1, (count_reg <= CNT_MAX), "kept count overran")
    `ADLP_ASSERT_NOW(a_frac_needs_dot, (frac_reg != '0), dot_seen_reg, "fraction without dot")
    `ADLP_ASSERT_NOW(a_stop_needs_dot, stopped_reg, dot_seen_reg, "stop without first dot")
    `ADLP_ASSERT_NEXT(a_term_clears, (step && is_term), (count_reg == '0), "frame not cleared")

endmodule

### src/adlp_out_reg.sv
// result register of the ascii distance line parser
// depends on adlp_pkg
`timescale 1ns / 1ps

module adlp_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  adlp_pkg::adlp_result_t      result,
    output logic                        blocked,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [adlp_pkg::DIST_W-1:0] distance_cm,
    output logic [adlp_pkg::RAW_W-1:0]  raw_cm
);
    import adlp_pkg::*;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DIST_W-1:0] distance_reg;
    logic [RAW_W-1:0]  raw_reg;

    // a waiting transaction holds the upstream byte
    assign blocked     = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign distance_cm = distance_reg;
    assign raw_cm      = raw_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (step)
        begin
            out_valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload load when a new result arrives
    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            distance_reg <= result.distance;
            raw_reg      <= result.raw;
        end
    end

endmodule

### src/ascii_distance_line_parser.sv
// ascii distance line parser: an accepted byte passes the input register, then its result
// is held in the output register; throughput one byte per cycle; a result waiting in the output
// register stalls input only when the input register is also full
// the bound registers sit at this level; reset clears all frame state and the
// bounds return to 20 cm and 4000 cm, no clearing pass is needed
`timescale 1ns / 1ps

`include "ascii_distance_line_parser_macros.svh"

module ascii_distance_line_parser #(
    parameter int MAX_KEPT_CHARS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [adlp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [adlp_pkg::DIST_W-1:0] distance_cm,
    output logic [adlp_pkg::RAW_W-1:0]  raw_cm,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [adlp_pkg::DIST_W-1:0] cfg_data
);
    import adlp_pkg::*;

    logic              step;
    logic              blocked;
    logic [BYTE_W-1:0] byte_q;
    adlp_result_t      result;
    logic [DIST_W-1:0] min_distance_reg;
    logic [DIST_W-1:0] max_distance_reg;

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RESET;
            max_distance_reg <= MAX_DISTANCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DISTANCE: min_distance_reg <= cfg_data;
                REG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                default:          min_distance_reg <= min_distance_reg;
            endcase
        end
    end

    adlp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .blocked  (blocked),
        .step     (step),
        .byte_q   (byte_q)
    );

    adlp_parse_core #(
        .MAX_KEPT_CHARS (MAX_KEPT_CHARS)
    ) u_parse_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .byte_q          (byte_q),
        .min_distance_cm (min_distance_reg),
        .max_distance_cm (max_distance_reg),
        .result          (result)
    );

    adlp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .result      (result),
        .blocked     (blocked),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance_cm (distance_cm),
        .raw_cm      (raw_cm)
    );

    // input backpressure only comes from a stalled result
    `ADLP_ASSERT_NOW(a_stall_cause, in_stall, (out_valid && out_stall), "stall without cause")
    `ADLP_ASSERT_NOW(a_no_step_blocked, blocked, !step, "byte moved while output full")

endmodule
